// File: rtl/ole_pkg.sv
// Package for the ordered list engine: sizes, codes and the entry record.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package ole_pkg;

   // list geometry
   localparam int CAPACITY  = 32;
   localparam int KEY_WIDTH = 64;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);

   // fixed field widths of the item channels
   localparam int CMD_W     = 2;
   localparam int POS_W     = 6;
   localparam int WORD_W    = 64;
   localparam int STATUS_W  = 2;
   localparam int FOUND_W   = 5;
   localparam int COUNT_W   = 6;

   // low KEY_WIDTH bits of a key are stored and compared
   localparam logic [WORD_W-1:0] KEY_MASK = WORD_W'({WORD_W{1'b1}} >> (WORD_W - KEY_WIDTH));

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_FIND   = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE     = 2'd0,
      ST_REJECT   = 2'd1,
      ST_NOTFOUND = 2'd2
   } status_type;

   typedef struct packed {
      logic [WORD_W-1:0] key;
      logic [WORD_W-1:0] payload_a;
      logic [WORD_W-1:0] payload_b;
   } entry_type;

   // write and read port groups of the entry memory
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } ram_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } ram_rd_type;

endpackage

`default_nettype wire

// File: rtl/ole_req_if.sv
// Command and result channels of the ordered list engine.
// Depends on ole_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ole_req_if import ole_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [POS_W-1:0]  position;
   logic [WORD_W-1:0] key;
   logic [WORD_W-1:0] payload_a;
   logic [WORD_W-1:0] payload_b;

   modport source (output valid, command, position, key, payload_a, payload_b,
                   input ready);
   modport sink   (input valid, command, position, key, payload_a, payload_b,
                   output ready);
endinterface

interface ole_rsp_if import ole_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FOUND_W-1:0]  found_position;
   logic [WORD_W-1:0]   entry_key;
   logic [WORD_W-1:0]   entry_payload_a;
   logic [WORD_W-1:0]   entry_payload_b;
   logic [COUNT_W-1:0]  entry_count;
   logic                is_full;
   logic                is_empty;

   modport source (output valid, status, found_position, entry_key, entry_payload_a,
                   entry_payload_b, entry_count, is_full, is_empty,
                   input ready);
   modport sink   (input valid, status, found_position, entry_key, entry_payload_a,
                   entry_payload_b, entry_count, is_full, is_empty,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/ole_entry_ram.sv
// Entry memory: one write port and one registered read port.
// Depends on ole_pkg for the entry record and port groups.
`timescale 1ns / 1ps
`default_nettype none

module ole_entry_ram
   import ole_pkg::*;
(
   input  wire logic       clock,
   input  wire ram_wr_type wr,
   input  wire ram_rd_type rd,
   output      entry_type  rd_data
);

   entry_type mem [CAPACITY];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read port, data registered and valid in the cycle after the address
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/ordered_list_engine.sv
// Ordered list engine: dense list of up to 32 entries with insert, remove, find, read.
// Each item walks n entries (insert: count - position, remove: count - position - 1,
// find: up to count, read: 1), one entry per cycle through the single memory read and
// write ports; a find stops at its first hit, and a rejected item walks none. A new item
// is taken only once the result of the last one is in the output register.
// Reset clears the count and handshakes, not the memory.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_engine
   import ole_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   ole_req_if.sink   req,
   ole_rsp_if.source rsp
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_RESULT
   } state_type;

   state_type           state_ff,     state_in;
   cmd_type             cmd_ff,       cmd_in;
   logic [POS_W-1:0]    pos_ff,       pos_in;
   entry_type           new_ff,       new_in;
   logic [CNT_W-1:0]    count_ff,     count_in;
   logic [CNT_W-1:0]    rd_ptr_ff,    rd_ptr_in;
   logic [CNT_W-1:0]    rd_left_ff,   rd_left_in;
   logic                pend_ff,      pend_in;
   logic [IDX_W-1:0]    pend_addr_ff, pend_addr_in;
   status_type          st_ff,        st_in;
   logic [FOUND_W-1:0]  found_ff,     found_in;
   entry_type           ent_ff,       ent_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [FOUND_W-1:0]  rsp_found_ff, rsp_found_in;
   entry_type           rsp_ent_ff,   rsp_ent_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_full_ff,  rsp_full_in;
   logic                rsp_empty_ff, rsp_empty_in;

   ram_wr_type          ram_wr;
   ram_rd_type          ram_rd;
   entry_type           rd_data;
   logic                issue;
   logic [CNT_W-1:0]    req_pos;

   ole_entry_ram u_entry_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (rd_data)
   );

   assign req.ready = (state_ff == S_IDLE);
   assign req_pos   = CNT_W'(req.position);
   assign issue     = (state_ff == S_RUN) && (rd_left_ff != '0);

   // sequencer: set up the walk, move one entry per cycle, then stage the result
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      pos_in       = pos_ff;
      new_in       = new_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_left_in   = rd_left_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      st_in        = st_ff;
      found_in     = found_ff;
      ent_in       = ent_ff;
      ram_wr       = '0;
      ram_rd.en    = issue;
      ram_rd.addr  = rd_ptr_ff[IDX_W-1:0];

      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_ent_in    = rsp_ent_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_empty_in  = rsp_empty_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cmd_in           = cmd_type'(req.command);
               pos_in           = req.position;
               new_in.key       = req.key & KEY_MASK;
               new_in.payload_a = req.payload_a;
               new_in.payload_b = req.payload_b;
               st_in            = ST_DONE;
               found_in         = '0;
               ent_in           = '0;
               rd_ptr_in        = '0;
               rd_left_in       = '0;
               state_in         = S_RUN;
               unique case (cmd_type'(req.command))
                  CMD_INSERT: begin
                     if (count_ff >= CNT_W'(CAPACITY) || req_pos > count_ff) begin
                        st_in    = ST_REJECT;
                        state_in = S_RESULT;
                     end else begin
                        rd_ptr_in  = count_ff - 1'b1;
                        rd_left_in = count_ff - req_pos;
                     end
                  end
                  CMD_REMOVE: begin
                     if (req_pos >= count_ff) begin
                        st_in    = ST_REJECT;
                        state_in = S_RESULT;
                     end else begin
                        rd_ptr_in  = req_pos + 1'b1;
                        rd_left_in = count_ff - req_pos - 1'b1;
                     end
                  end
                  CMD_FIND: begin
                     rd_left_in = count_ff;
                  end
                  CMD_READ: begin
                     if (req_pos >= count_ff) begin
                        st_in    = ST_REJECT;
                        state_in = S_RESULT;
                     end else begin
                        rd_ptr_in  = req_pos;
                        rd_left_in = CNT_W'(1);
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_RUN: begin
            // advance the read pointer
            if (issue) begin
               rd_left_in   = rd_left_ff - 1'b1;
               rd_ptr_in    = (cmd_ff == CMD_INSERT) ? rd_ptr_ff - 1'b1 : rd_ptr_ff + 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = rd_ptr_ff[IDX_W-1:0];
            end
            if (pend_ff) begin
               // handle the entry read last cycle
               case (cmd_ff)
                  CMD_INSERT: begin
                     ram_wr.en   = 1'b1;
                     ram_wr.addr = pend_addr_ff + 1'b1;
                     ram_wr.data = rd_data;
                  end
                  CMD_REMOVE: begin
                     ram_wr.en   = 1'b1;
                     ram_wr.addr = pend_addr_ff - 1'b1;
                     ram_wr.data = rd_data;
                  end
                  CMD_FIND: begin
                     if (rd_data.key == new_ff.key) begin
                        found_in = FOUND_W'(pend_addr_ff);
                        ent_in   = rd_data;
                        pend_in  = 1'b0;
                        state_in = S_RESULT;
                     end
                  end
                  default: begin
                     ent_in   = rd_data;
                     pend_in  = 1'b0;
                     state_in = S_RESULT;
                  end
               endcase
            end else if (!issue) begin
               // walk finished: place the new entry or settle the count
               state_in = S_RESULT;
               case (cmd_ff)
                  CMD_INSERT: begin
                     ram_wr.en   = 1'b1;
                     ram_wr.addr = pos_ff[IDX_W-1:0];
                     ram_wr.data = new_ff;
                     count_in    = count_ff + 1'b1;
                  end
                  CMD_REMOVE: count_in = count_ff - 1'b1;
                  CMD_FIND:   st_in    = ST_NOTFOUND;
                  default:    st_in    = ST_DONE;
               endcase
            end
         end

         S_RESULT: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_found_in  = found_ff;
               rsp_ent_in    = ent_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_full_in   = (count_ff == CNT_W'(CAPACITY));
               rsp_empty_in  = (count_ff == '0);
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // state, walk counters and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      new_ff        <= new_in;
      rd_ptr_ff     <= rd_ptr_in;
      rd_left_ff    <= rd_left_in;
      pend_addr_ff  <= pend_addr_in;
      st_ff         <= st_in;
      found_ff      <= found_in;
      ent_ff        <= ent_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_ent_ff    <= rsp_ent_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = rsp_status_ff;
   assign rsp.found_position  = rsp_found_ff;
   assign rsp.entry_key       = rsp_ent_ff.key;
   assign rsp.entry_payload_a = rsp_ent_ff.payload_a;
   assign rsp.entry_payload_b = rsp_ent_ff.payload_b;
   assign rsp.entry_count     = rsp_count_ff;
   assign rsp.is_full         = rsp_full_ff;
   assign rsp.is_empty        = rsp_empty_ff;

   // the list never grows past its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   // the memory is written only while a command walks the list
   a_write_in_run: assert property (@(posedge clock) disable iff (reset)
      ram_wr.en |-> state_ff == S_RUN)
      else $error("entry write outside a walk");

   // the count moves only while a command walks the list
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_RUN |=> $stable(count_ff))
      else $error("entry count changed outside a walk");

   // a new item is not taken in the cycle after one was taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("item accepted while busy");

endmodule

`default_nettype wire

// File: test/list_checker.sv
// Checker for the ordered list engine: watches both item channels, predicts each reply
// from its own copy of the list and compares it field by field.
// Depends on ole_pkg and the ole_req_if / ole_rsp_if interfaces.
`timescale 1ns / 1ps

module list_checker
   import ole_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   ole_req_if        req_chan,
   ole_rsp_if        rsp_chan,
   output int        fail_count,
   output int        pending_count
);

   localparam int SHOW_LIMIT = 10;

   typedef struct packed {
      status_type          status;
      logic [FOUND_W-1:0]  found;
      entry_type           entry;
      logic [COUNT_W-1:0]  count;
      logic                full;
      logic                empty;
   } list_reply_type;

   // predicted list contents and fill level
   entry_type      entry_rows [CAPACITY];
   int             entry_total;
   list_reply_type replies_due [$];

   // apply one command to the list copy and return the reply it must produce
   function automatic list_reply_type apply_command(cmd_type cmd, logic [POS_W-1:0] pos,
                                                    logic [WORD_W-1:0] key,
                                                    logic [WORD_W-1:0] payload_a,
                                                    logic [WORD_W-1:0] payload_b);
      list_reply_type    r;
      int                p;
      bit                hit;
      logic [WORD_W-1:0] k;
      r        = '0;
      r.status = ST_DONE;
      p        = pos;
      hit      = 1'b0;
      k        = key & KEY_MASK;
      case (cmd)
         CMD_INSERT: begin
            if (entry_total >= CAPACITY || p > entry_total) begin
               r.status = ST_REJECT;
            end else begin
               // open a slot at p by moving the tail up
               for (int i = entry_total; i > p; i--) entry_rows[i] = entry_rows[i-1];
               entry_rows[p].key       = k;
               entry_rows[p].payload_a = payload_a;
               entry_rows[p].payload_b = payload_b;
               entry_total++;
            end
         end
         CMD_REMOVE: begin
            if (p >= entry_total) begin
               r.status = ST_REJECT;
            end else begin
               // close the gap by moving the tail down
               for (int i = p; i + 1 < entry_total; i++) entry_rows[i] = entry_rows[i+1];
               entry_total--;
            end
         end
         CMD_FIND: begin
            r.status = ST_NOTFOUND;
            // lowest matching position wins
            for (int i = 0; i < entry_total && !hit; i++) begin
               if (entry_rows[i].key == k) begin
                  hit      = 1'b1;
                  r.status = ST_DONE;
                  r.found  = i[FOUND_W-1:0];
                  r.entry  = entry_rows[i];
               end
            end
         end
         default: begin
            if (p >= entry_total) r.status = ST_REJECT;
            else                  r.entry  = entry_rows[p];
         end
      endcase
      r.count = entry_total[COUNT_W-1:0];
      r.full  = (entry_total == CAPACITY);
      r.empty = (entry_total == 0);
      return r;
   endfunction

   // flag one differing field, report it while under the display limit
   function automatic bit field_diff(string name, logic [WORD_W-1:0] want,
                                     logic [WORD_W-1:0] got);
      if (want !== got) begin
         if (fail_count < SHOW_LIMIT)
            $display("[%0t] reply mismatch on %s: expected %0h, got %0h",
                     $time, name, want, got);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // predict on each accepted command, check each accepted reply
   always @(posedge clock) begin
      list_reply_type want;
      bit             bad;
      if (reset) begin
         entry_total = 0;
         replies_due.delete();
      end else begin
         if (req_chan.valid && req_chan.ready)
            replies_due.push_back(apply_command(cmd_type'(req_chan.command),
                                                req_chan.position, req_chan.key,
                                                req_chan.payload_a, req_chan.payload_b));
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (replies_due.size() == 0) begin
               if (fail_count < SHOW_LIMIT)
                  $display("[%0t] reply with no command outstanding", $time);
               fail_count++;
            end else begin
               want = replies_due.pop_front();
               bad  = 1'b0;
               bad |= field_diff("status", WORD_W'(want.status),
                                 WORD_W'(rsp_chan.status));
               bad |= field_diff("found_position", WORD_W'(want.found),
                                 WORD_W'(rsp_chan.found_position));
               bad |= field_diff("entry_key", want.entry.key, rsp_chan.entry_key);
               bad |= field_diff("entry_payload_a", want.entry.payload_a,
                                 rsp_chan.entry_payload_a);
               bad |= field_diff("entry_payload_b", want.entry.payload_b,
                                 rsp_chan.entry_payload_b);
               bad |= field_diff("entry_count", WORD_W'(want.count),
                                 WORD_W'(rsp_chan.entry_count));
               bad |= field_diff("is_full", WORD_W'(want.full), WORD_W'(rsp_chan.is_full));
               bad |= field_diff("is_empty", WORD_W'(want.empty),
                                 WORD_W'(rsp_chan.is_empty));
               if (bad) fail_count++;
            end
         end
      end
      pending_count = replies_due.size();
   end

endmodule

// File: test/testbench.sv
// Top of the ordered list engine bench: clock, reset, command stimulus and reply
// back-pressure, with list_checker alongside the block; prints the verdict.
// Depends on ole_pkg, the channel interfaces, ordered_list_engine and list_checker.
`timescale 1ns / 1ps

module testbench;
   import ole_pkg::*;

   localparam int PHASE_ITEMS  = 530;
   localparam int SWING_ITEMS  = 100;
   localparam int STALL_AT     = 1250;
   localparam int STALL_CYCLES = 300;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int SETTLE       = 50;

   localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;

   ole_req_if req_chan ();
   ole_rsp_if rsp_chan ();

   int fail_count;
   int pending_count;
   int cycle_count  = 0;
   int sent_count   = 0;
   int tx_idle_pct  = 0;
   int rx_idle_pct  = 0;
   int stall_left;
   bit stall_done   = 1'b0;

   // keys currently held, in list order; steers positions and find keys
   logic [WORD_W-1:0] key_mirror [$];

   ordered_list_engine u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   list_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop for a hung block
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // reply side: random back-pressure, plus one long hold-off while commands keep coming
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!stall_done && sent_count >= STALL_AT) begin
            rsp_chan.ready = 1'b0;
            for (stall_left = STALL_CYCLES; stall_left > 0; stall_left--) @(negedge clock);
            stall_done = 1'b1;
         end
         rsp_chan.ready = !reset && ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // offer one command, hold it until accepted, then track the key list
   task automatic send_command(cmd_type cmd, logic [POS_W-1:0] pos, logic [WORD_W-1:0] key,
                               logic [WORD_W-1:0] payload_a, logic [WORD_W-1:0] payload_b);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.command   = cmd;
      req_chan.position  = pos;
      req_chan.key       = key;
      req_chan.payload_a = payload_a;
      req_chan.payload_b = payload_b;
      req_chan.valid     = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
      if (cmd == CMD_INSERT && key_mirror.size() < CAPACITY && pos <= key_mirror.size())
         key_mirror.insert(pos, key & KEY_MASK);
      else if (cmd == CMD_REMOVE && pos < key_mirror.size())
         key_mirror.delete(pos);
      @(negedge clock);
   endtask

   // narrow keys often, so that duplicates and hits are common
   function automatic logic [WORD_W-1:0] pick_key();
      if ($urandom_range(0, 99) < 30) return WORD_W'($urandom_range(0, 7));
      return {$urandom, $urandom};
   endfunction

   // one random command; grow favors inserts, otherwise removes dominate
   task automatic send_random(bit grow);
      int                r;
      int                n;
      int                pos;
      cmd_type           cmd;
      logic [WORD_W-1:0] key;
      n = key_mirror.size();
      r = $urandom_range(0, 99);
      if (grow) cmd = (r < 55) ? CMD_INSERT : (r < 65) ? CMD_REMOVE :
                      (r < 85) ? CMD_FIND : CMD_READ;
      else      cmd = (r < 10) ? CMD_INSERT : (r < 55) ? CMD_REMOVE :
                      (r < 80) ? CMD_FIND : CMD_READ;
      if ($urandom_range(0, 9) == 0)  pos = $urandom_range(0, 63);
      else if (cmd == CMD_INSERT)     pos = $urandom_range(0, n);
      else if (n > 0)                 pos = $urandom_range(0, n - 1);
      else                            pos = 0;
      if (cmd == CMD_FIND && n > 0 && $urandom_range(0, 99) < 65)
         key = key_mirror[$urandom_range(0, n - 1)];
      else
         key = pick_key();
      send_command(cmd, POS_W'(pos), key, {$urandom, $urandom}, {$urandom, $urandom});
   endtask

   // lower valid and hold until every reply is back
   task automatic drain();
      req_chan.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic run_phase(int tx_pct, int rx_pct);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int i = 0; i < PHASE_ITEMS; i++) send_random(((i / SWING_ITEMS) % 2) == 0);
      drain();
   endtask

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.command   = CMD_INSERT;
      req_chan.position  = '0;
      req_chan.key       = '0;
      req_chan.payload_a = '0;
      req_chan.payload_b = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty list, bounds, shifts, duplicate keys, last entry
      send_command(CMD_READ,   0,  '0, '0, '0);
      send_command(CMD_REMOVE, 0,  '0, '0, '0);
      send_command(CMD_FIND,   0,  '0, '0, '0);
      send_command(CMD_INSERT, 1,  64'h11, 64'h22, 64'h33);
      send_command(CMD_INSERT, 0,  ALL_ONES, ALL_ONES, ALL_ONES);
      send_command(CMD_INSERT, 1,  '0, '0, '0);
      send_command(CMD_INSERT, 0,  64'h5, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
      send_command(CMD_INSERT, 3,  64'h5, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
      send_command(CMD_INSERT, 63, 64'h7, 64'h1, 64'h2);
      send_command(CMD_FIND,   63, 64'h5, ALL_ONES, ALL_ONES);
      send_command(CMD_FIND,   0,  ALL_ONES, '0, '0);
      send_command(CMD_READ,   3,  '0, '0, '0);
      send_command(CMD_READ,   4,  '0, '0, '0);
      send_command(CMD_READ,   63, ALL_ONES, ALL_ONES, ALL_ONES);
      send_command(CMD_REMOVE, 0,  '0, '0, '0);
      send_command(CMD_FIND,   0,  64'h5, '0, '0);
      send_command(CMD_REMOVE, 3,  '0, '0, '0);
      send_command(CMD_REMOVE, 2,  '0, '0, '0);
      send_command(CMD_FIND,   0,  64'h5, '0, '0);
      send_command(CMD_FIND,   0,  '0, '0, '0);
      send_command(CMD_READ,   0,  '0, '0, '0);
      send_command(CMD_REMOVE, 0,  '0, '0, '0);
      send_command(CMD_REMOVE, 0,  '0, '0, '0);
      send_command(CMD_READ,   0,  '0, '0, '0);
      drain();

      // random: slow receiver, then slow sender, then full rate
      run_phase(38, 87);
      run_phase(87, 38);
      run_phase(0, 0);

      repeat (SETTLE) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) $display("All tests passed");
      else                                       $display("Some tests failed");
      $finish;
   end

endmodule
